[rtl/core/iso8601_utc_timestamp_parser_unit_macros.svh]
// Assertion macros shared by the timestamp parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ISO8601_UTC_TIMESTAMP_PARSER_UNIT_MACROS_SVH
`define ISO8601_UTC_TIMESTAMP_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define ITSP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itsp: same-cycle check failed");

// next-cycle implication
`define ITSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itsp: next-cycle check failed");

`endif

[rtl/core/itsp_pkg.sv]
// Shared types, constants and table functions of the timestamp parser.
// No dependencies; used by every module of the block.
`default_nettype none

package itsp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned ACC_W   = 7;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned EPOCH_W = 39;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DOY_W   = 9;
   localparam int unsigned HMS_W   = 17;
   localparam int unsigned DAY_W   = 25;

   localparam int unsigned QUEUE_DEPTH = 2;

   // character positions
   localparam logic [POS_W-1:0] POS_YEAR_LO = 5'd2;
   localparam logic [POS_W-1:0] POS_DASH_A  = 5'd4;
   localparam logic [POS_W-1:0] POS_DASH_B  = 5'd7;
   localparam logic [POS_W-1:0] POS_T       = 5'd10;
   localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
   localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
   localparam logic [POS_W-1:0] POS_Z       = 5'd19;
   localparam logic [POS_W-1:0] STAMP_LEN   = 5'd20;
   localparam logic [POS_W-1:0] POS_MAX     = 5'd31;

   // characters
   localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_T_UC  = 8'h54;
   localparam logic [CHAR_W-1:0] CH_T_LC  = 8'h74;
   localparam logic [CHAR_W-1:0] CH_Z_UC  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_Z_LC  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

   // day count from 0000-03-01 (shifted by 400 years) to 1970-01-01
   localparam logic [DAY_W-1:0] DAY_OFFSET = 25'd865565;
   localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;

   // one finished string, handed from front to back
   typedef struct packed {
      logic             fmt_ok;
      logic [ACC_W-1:0] year_hi;
      logic [ACC_W-1:0] year_lo;
      logic [ACC_W-1:0] month;
      logic [ACC_W-1:0] day;
      logic [ACC_W-1:0] hour;
      logic [ACC_W-1:0] minute;
      logic [ACC_W-1:0] second;
   } stamp_rec_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_DAYS,
      BK_SECS,
      BK_SEND
   } back_state_type;

   function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                    input logic [3:0] dig);
      logic [10:0] w;
      w = {4'd0, acc} * 11'd10 + {7'd0, dig};
      return w[ACC_W-1:0];
   endfunction

   // days in month; zero for a month code outside 1..12
   function automatic logic [4:0] month_len(input logic [ACC_W-1:0] month,
                                            input logic leap);
      logic [4:0] n;
      case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                   n = 5'd30;
         7'd2:                                       n = leap ? 5'd29 : 5'd28;
         default:                                    n = 5'd0;
      endcase
      return n;
   endfunction

   // days before the first of the month, year starting in March
   function automatic logic [DOY_W-1:0] doy_base(input logic [ACC_W-1:0] month);
      logic [DOY_W-1:0] n;
      case (month)
         7'd3:    n = 9'd0;
         7'd4:    n = 9'd31;
         7'd5:    n = 9'd61;
         7'd6:    n = 9'd92;
         7'd7:    n = 9'd122;
         7'd8:    n = 9'd153;
         7'd9:    n = 9'd184;
         7'd10:   n = 9'd214;
         7'd11:   n = 9'd245;
         7'd12:   n = 9'd275;
         7'd1:    n = 9'd306;
         7'd2:    n = 9'd337;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/core/itsp_front.sv]
// Front end: takes one character per transfer, checks the form, accumulates digits.
// Depends on itsp_pkg; pushes one stamp_rec_type per string into itsp_queue.
`default_nettype none

module itsp_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         char_valid,
   output      logic                         char_ready,
   input  wire logic [itsp_pkg::CHAR_W-1:0]  char_byte,
   input  wire logic                         last_char,
   input  wire logic                         queue_full,
   output      logic                         rec_push,
   output      itsp_pkg::stamp_rec_type      rec
);

   logic [itsp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       err_ff, err_in;
   logic [itsp_pkg::ACC_W-1:0] yhi_ff, yhi_in, ylo_ff, ylo_in;
   logic [itsp_pkg::ACC_W-1:0] mon_ff, mon_in, day_ff, day_in;
   logic [itsp_pkg::ACC_W-1:0] hr_ff, hr_in, min_ff, min_in, sec_ff, sec_in;
   logic                       take;
   logic                       is_digit;
   logic [3:0]                 dig;
   logic [itsp_pkg::CHAR_W-1:0] dig_full;

   assign char_ready = !queue_full;
   assign take       = char_valid && char_ready;
   assign is_digit   = char_byte inside {[itsp_pkg::CH_0:itsp_pkg::CH_9]};
   assign dig_full   = char_byte - itsp_pkg::CH_0;
   assign dig        = dig_full[3:0];

   // accumulators after this character
   always_comb begin
      err_in = err_ff;
      yhi_in = yhi_ff;
      ylo_in = ylo_ff;
      mon_in = mon_ff;
      day_in = day_ff;
      hr_in  = hr_ff;
      min_in = min_ff;
      sec_in = sec_ff;
      if (pos_ff >= itsp_pkg::STAMP_LEN) begin
         err_in = 1'b1;
      end else if (pos_ff inside {itsp_pkg::POS_DASH_A, itsp_pkg::POS_DASH_B}) begin
         if (char_byte != itsp_pkg::CH_DASH) err_in = 1'b1;
      end else if (pos_ff inside {itsp_pkg::POS_COLON_A, itsp_pkg::POS_COLON_B}) begin
         if (char_byte != itsp_pkg::CH_COLON) err_in = 1'b1;
      end else if (pos_ff == itsp_pkg::POS_T) begin
         if (!(char_byte inside {itsp_pkg::CH_T_UC, itsp_pkg::CH_T_LC})) err_in = 1'b1;
      end else if (pos_ff == itsp_pkg::POS_Z) begin
         if (!(char_byte inside {itsp_pkg::CH_Z_UC, itsp_pkg::CH_Z_LC})) err_in = 1'b1;
      end else if (!is_digit) begin
         err_in = 1'b1;
      end else if (pos_ff < itsp_pkg::POS_YEAR_LO) begin
         yhi_in = itsp_pkg::push_digit(yhi_ff, dig);
      end else if (pos_ff < itsp_pkg::POS_DASH_A) begin
         ylo_in = itsp_pkg::push_digit(ylo_ff, dig);
      end else if (pos_ff < itsp_pkg::POS_DASH_B) begin
         mon_in = itsp_pkg::push_digit(mon_ff, dig);
      end else if (pos_ff < itsp_pkg::POS_T) begin
         day_in = itsp_pkg::push_digit(day_ff, dig);
      end else if (pos_ff < itsp_pkg::POS_COLON_A) begin
         hr_in = itsp_pkg::push_digit(hr_ff, dig);
      end else if (pos_ff < itsp_pkg::POS_COLON_B) begin
         min_in = itsp_pkg::push_digit(min_ff, dig);
      end else begin
         sec_in = itsp_pkg::push_digit(sec_ff, dig);
      end
   end

   always_comb begin
      rec.fmt_ok  = !err_in && (pos_ff == itsp_pkg::POS_Z);
      rec.year_hi = yhi_in;
      rec.year_lo = ylo_in;
      rec.month   = mon_in;
      rec.day     = day_in;
      rec.hour    = hr_in;
      rec.minute  = min_in;
      rec.second  = sec_in;
   end

   assign rec_push = take && last_char;

   always_comb begin
      pos_in = pos_ff;
      if (pos_ff != itsp_pkg::POS_MAX) pos_in = pos_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset || rec_push) begin
         pos_ff <= '0;
         err_ff <= 1'b0;
         yhi_ff <= '0;
         ylo_ff <= '0;
         mon_ff <= '0;
         day_ff <= '0;
         hr_ff  <= '0;
         min_ff <= '0;
         sec_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
         err_ff <= err_in;
         yhi_ff <= yhi_in;
         ylo_ff <= ylo_in;
         mon_ff <= mon_in;
         day_ff <= day_in;
         hr_ff  <= hr_in;
         min_ff <= min_in;
         sec_ff <= sec_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/itsp_queue.sv]
// Short queue of finished strings between the front and back ends.
// Depends on itsp_pkg for the record type.
`default_nettype none

module itsp_queue #(
   parameter int unsigned DEPTH = itsp_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire itsp_pkg::stamp_rec_type push_rec,
   output      logic                    full,
   input  wire logic                    pop,
   output      itsp_pkg::stamp_rec_type pop_rec,
   output      logic                    not_empty
);

   `include "iso8601_utc_timestamp_parser_unit_macros.svh"

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   itsp_pkg::stamp_rec_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign pop_rec   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_rec;
   end

   `ITSP_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full)
   `ITSP_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, not_empty)
   `ITSP_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)

endmodule

`default_nettype wire

[rtl/core/itsp_back.sv]
// Back end: range checks and epoch conversion of one finished string, then the result register.
// Depends on itsp_pkg; pulls records from itsp_queue.
`default_nettype none

module itsp_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                rec_valid,
   input  wire itsp_pkg::stamp_rec_type             rec,
   output      logic                                rec_pop,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_ok,
   output      logic signed [itsp_pkg::EPOCH_W-1:0] rsp_epoch
);

   `include "iso8601_utc_timestamp_parser_unit_macros.svh"

   itsp_pkg::back_state_type state_ff, state_in;
   itsp_pkg::stamp_rec_type  rec_ff;
   logic                     load_rsp;

   // prep stage
   logic                        leap_w, early_w, borrow_w, ok_w;
   logic [4:0]                  mdays_w;
   logic [itsp_pkg::ACC_W-1:0]  hp_w, lp_w;
   logic [itsp_pkg::YEAR_W-1:0] yp_w;
   logic [itsp_pkg::DOY_W-1:0]  doy_w;
   logic [itsp_pkg::HMS_W-1:0]  hms_w;
   logic                        ok_ff;
   logic [itsp_pkg::ACC_W-1:0]  hp_ff, lp_ff;
   logic [itsp_pkg::YEAR_W-1:0] yp_ff;
   logic [itsp_pkg::DOY_W-1:0]  doy_ff;
   logic [itsp_pkg::HMS_W-1:0]  hms_ff;

   // day and second stages
   logic [itsp_pkg::DAY_W-1:0]         day_sum_w;
   logic signed [itsp_pkg::DAY_W-1:0]  day_ff;
   logic signed [42:0]                 prod_w;
   logic [itsp_pkg::EPOCH_W-1:0]       sec_w, sec_ff;

   logic                                rsp_valid_ff;
   logic                                rsp_ok_ff;
   logic signed [itsp_pkg::EPOCH_W-1:0] rsp_epoch_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itsp_pkg::BK_IDLE: if (rec_valid) state_in = itsp_pkg::BK_PREP;
         itsp_pkg::BK_PREP: state_in = itsp_pkg::BK_DAYS;
         itsp_pkg::BK_DAYS: state_in = itsp_pkg::BK_SECS;
         itsp_pkg::BK_SECS: state_in = itsp_pkg::BK_SEND;
         itsp_pkg::BK_SEND: if (!rsp_valid_ff || rsp_ready) state_in = itsp_pkg::BK_IDLE;
         default:           state_in = itsp_pkg::BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      rec_pop  = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         itsp_pkg::BK_IDLE: rec_pop  = rec_valid;
         itsp_pkg::BK_SEND: load_rsp = !rsp_valid_ff || rsp_ready;
         default: begin
            rec_pop  = 1'b0;
            load_rsp = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= itsp_pkg::BK_IDLE;
      else       state_ff <= state_in;
   end

   // range checks; year shifted by 400 and started in March
   always_comb begin
      leap_w   = (rec_ff.year_lo != '0) ? (rec_ff.year_lo[1:0] == 2'b00)
                                        : (rec_ff.year_hi[1:0] == 2'b00);
      mdays_w  = itsp_pkg::month_len(rec_ff.month, leap_w);
      ok_w     = rec_ff.fmt_ok &&
                 (rec_ff.month != '0) && (rec_ff.month <= 7'd12) &&
                 (rec_ff.day != '0) && (rec_ff.day <= {2'b00, mdays_w}) &&
                 (rec_ff.hour <= 7'd23) && (rec_ff.minute <= 7'd59) &&
                 (rec_ff.second <= 7'd60);
      early_w  = (rec_ff.month <= 7'd2);
      borrow_w = early_w && (rec_ff.year_lo == '0);
      hp_w     = rec_ff.year_hi + 7'd4 - {6'd0, borrow_w};
      if (!early_w)      lp_w = rec_ff.year_lo;
      else if (borrow_w) lp_w = 7'd99;
      else               lp_w = rec_ff.year_lo - 7'd1;
      yp_w     = itsp_pkg::YEAR_W'(hp_w) * 14'd100 + itsp_pkg::YEAR_W'(lp_w);
      doy_w    = itsp_pkg::doy_base(rec_ff.month) + itsp_pkg::DOY_W'(rec_ff.day) - 9'd1;
      hms_w    = itsp_pkg::HMS_W'(rec_ff.hour) * 17'd3600 +
                 itsp_pkg::HMS_W'(rec_ff.minute) * 17'd60 +
                 itsp_pkg::HMS_W'(rec_ff.second);
   end

   // 365*Y + Y/4 - Y/100 + Y/400 with Y = 100*hp + lp
   assign day_sum_w = itsp_pkg::DAY_W'(yp_ff) * 25'd365 +
                      itsp_pkg::DAY_W'(hp_ff) * 25'd24 +
                      itsp_pkg::DAY_W'(hp_ff >> 2) +
                      itsp_pkg::DAY_W'(lp_ff >> 2) +
                      itsp_pkg::DAY_W'(doy_ff) - itsp_pkg::DAY_OFFSET;

   assign prod_w = day_ff * itsp_pkg::SEC_PER_DAY;
   assign sec_w  = prod_w[itsp_pkg::EPOCH_W-1:0] +
                   {{(itsp_pkg::EPOCH_W - itsp_pkg::HMS_W){1'b0}}, hms_ff};

   always_ff @(posedge clock) begin
      if (rec_pop) rec_ff <= rec;
      if (state_ff == itsp_pkg::BK_PREP) begin
         ok_ff  <= ok_w;
         hp_ff  <= hp_w;
         lp_ff  <= lp_w;
         yp_ff  <= yp_w;
         doy_ff <= doy_w;
         hms_ff <= hms_w;
      end
      if (state_ff == itsp_pkg::BK_DAYS) day_ff <= $signed(day_sum_w);
      if (state_ff == itsp_pkg::BK_SECS) sec_ff <= sec_w;
      if (load_rsp) begin
         rsp_ok_ff    <= ok_ff;
         rsp_epoch_ff <= ok_ff ? $signed(sec_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (load_rsp)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_epoch = rsp_epoch_ff;

   `ITSP_ASSERT_IMPLIES(a_zero_when_bad, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_epoch_ff == '0)
   `ITSP_ASSERT_NEXT(a_pop_to_prep, clock, reset, rec_pop, state_ff == itsp_pkg::BK_PREP)
   `ITSP_ASSERT_NEXT(a_load_shows, clock, reset, load_rsp, rsp_valid_ff && (state_ff == itsp_pkg::BK_IDLE))

endmodule

`default_nettype wire

[rtl/core/iso8601_utc_timestamp_parser_unit.sv]
// Top level of the ISO 8601 UTC timestamp parser: front end, record queue, back end.
// Depends on itsp_pkg, itsp_front, itsp_queue and itsp_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | req_tvalid/tready  | tdata[7:0] char_byte, tlast last_char
//  rsp     | out | rsp_tvalid/tready  | tdata[38:0] epoch_seconds, tuser parse_ok
//
// Front takes one character a cycle while the record queue has room; the queue
//   fills only when the back end falls behind, which drops req_tready.
// Back end takes each string through pop, checks, day count, day*86400 multiply and
//   result load, one string at a time, then holds until the result register frees up.
// Sustained: one byte per cycle for long enough strings while the receiver keeps up;
//   shorter strings are limited by the back-end sequencer.
// Reset is synchronous and clears counters, flags and handshakes; no memory sweep.
`default_nettype none

module iso8601_utc_timestamp_parser_unit #(
   parameter int unsigned QUEUE_DEPTH = itsp_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // character stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   input  wire logic        req_tlast,   // last_char
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // [38:0] epoch_seconds (signed), [39] zero
   output      logic        rsp_tuser    // parse_ok
);

   itsp_pkg::stamp_rec_type push_rec, pop_rec;
   logic rec_push, rec_pop, q_full, q_not_empty;
   logic rsp_ok;
   logic signed [itsp_pkg::EPOCH_W-1:0] rsp_epoch;

   itsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .char_valid (req_tvalid),
      .char_ready (req_tready),
      .char_byte  (req_tdata),
      .last_char  (req_tlast),
      .queue_full (q_full),
      .rec_push   (rec_push),
      .rec        (push_rec)
   );

   // finished strings wait here while the back end converts
   itsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_rec  (push_rec),
      .full      (q_full),
      .pop       (rec_pop),
      .pop_rec   (pop_rec),
      .not_empty (q_not_empty)
   );

   itsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (q_not_empty),
      .rec       (pop_rec),
      .rec_pop   (rec_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_ok    (rsp_ok),
      .rsp_epoch (rsp_epoch)
   );

   // zero fill to a whole byte
   assign rsp_tdata = {1'b0, rsp_epoch};
   assign rsp_tuser = rsp_ok;

endmodule

`default_nettype wire

[bench/tb_iso8601_utc_timestamp_parser_unit.sv]
// Self-checking bench for the ISO 8601 UTC timestamp parser: directed strings, then random
// stamps, damaged stamps and byte noise. Results are scored against an in-bench predictor.
// Depends on itsp_pkg and iso8601_utc_timestamp_parser_unit.
`default_nettype none

module tb_iso8601_utc_timestamp_parser_unit;

   localparam int     ITEM_TARGET = 1950;
   localparam int     CYCLE_LIMIT = 500000;
   localparam int     LONG_HOLD   = 400;   // receiver hold-off while the sender keeps pushing
   localparam int     TAIL_CYCLES = 32;    // settle time after the last result, before the verdict
   localparam int     SHORT_RUNS  = 30;
   localparam int     DAY0_1970   = 719528; // days from 0000-01-01 to 1970-01-01

   // one byte of stimulus plus the sender's and checker's side information
   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;     // goes out on tlast
      logic        typed;   // result below is typed in, not predicted
      logic        ok;
      logic [38:0] secs;
      logic        drain;   // sender waits for all results before this byte
      logic        hold;    // receiver starts a long hold-off here
      logic        burst;   // no sender gap
   } char_item_type;

   typedef struct packed {
      logic        ok;
      logic [39:0] data;
   } epoch_rsp_type;

   typedef struct {
      string  text;
      bit     typed;
      bit     ok;
      longint secs;
   } stamp_row_type;

   typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY } rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] char_byte
   logic        req_tlast  = 1'b0;  // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [38:0] epoch_seconds, [39] zero
   logic        rsp_tuser;          // parse_ok

   iso8601_utc_timestamp_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // directed strings; typed rows carry their result, the rest go through the predictor
   stamp_row_type stamp_table [25] = '{
      '{"1970-01-01T00:00:00Z", 1'b1, 1'b1, 64'sd0},
      '{"0000-01-01T00:00:00Z", 1'b1, 1'b1, -64'sd62167219200},
      '{"9999-12-31T23:59:60Z", 1'b1, 1'b1, 64'sd253402300800},
      '{"1969-12-31t23:59:59z", 1'b0, 1'b0, 64'sd0},
      '{"2000-02-29T12:34:56Z", 1'b0, 1'b0, 64'sd0},
      '{"2024-02-29T23:59:59Z", 1'b0, 1'b0, 64'sd0},
      '{"2038-01-19T03:14:08Z", 1'b0, 1'b0, 64'sd0},
      '{"1900-02-29T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-02-29T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-04-31T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-00-10T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-13-10T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-00T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-32T00:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-10T24:00:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-10T23:60:00Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-10T23:59:61Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-99-99T99:99:99Z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-10X23:59:59Z", 1'b1, 1'b0, 64'sd0},
      '{"2023/05-10T23:59:59Z", 1'b1, 1'b0, 64'sd0},
      '{"20a3-05-10T23:59:59z", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-10T23:59:59Zz", 1'b1, 1'b0, 64'sd0},
      '{"2023-05-10T23:59:5Z", 1'b1, 1'b0, 64'sd0},
      '{"Z", 1'b1, 1'b0, 64'sd0},
      '{"1970-01-01T00:00:00Z1970-01-01T00:00:00Z", 1'b1, 1'b0, 64'sd0}
   };

   char_item_type char_stream [$];
   epoch_rsp_type pending_epochs [$];
   logic [7:0] str_buf [$];
   bit         drain_next   = 1'b0;
   int         taken        = 0;
   int         errors       = 0;
   int         holds_asked  = 0;
   int         holds_served = 0;

   // predictor copy of the parser state
   logic [4:0]  st_pos  = '0;
   logic        st_bad  = 1'b0;
   logic [13:0] st_year = '0;
   logic [6:0]  st_mon  = '0;
   logic [6:0]  st_day  = '0;
   logic [6:0]  st_hr   = '0;
   logic [6:0]  st_min  = '0;
   logic [6:0]  st_sec  = '0;

   // Gregorian month length, zero outside 1..12
   function automatic int days_in_month(input int y, input int m);
      bit leap;
      leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // one accepted byte; on tlast returns the parse result and clears the state
   function automatic void parse_char(input logic [7:0] ch, input logic fin,
                                      output logic got, output epoch_rsp_type res);
      logic [4:0] at;
      logic [3:0] dig;
      logic       good;
      int         yl, ml, dl, days;
      longint     secs;
      at  = st_pos;
      dig = ch[3:0];
      if (at >= itsp_pkg::STAMP_LEN) begin
         st_bad = 1'b1;
      end else if (at == itsp_pkg::POS_DASH_A || at == itsp_pkg::POS_DASH_B) begin
         if (ch != itsp_pkg::CH_DASH) st_bad = 1'b1;
      end else if (at == itsp_pkg::POS_COLON_A || at == itsp_pkg::POS_COLON_B) begin
         if (ch != itsp_pkg::CH_COLON) st_bad = 1'b1;
      end else if (at == itsp_pkg::POS_T) begin
         if (ch != itsp_pkg::CH_T_UC && ch != itsp_pkg::CH_T_LC) st_bad = 1'b1;
      end else if (at == itsp_pkg::POS_Z) begin
         if (ch != itsp_pkg::CH_Z_UC && ch != itsp_pkg::CH_Z_LC) st_bad = 1'b1;
      end else if (ch < itsp_pkg::CH_0 || ch > itsp_pkg::CH_9) begin
         st_bad = 1'b1;
      end else if (at < itsp_pkg::POS_DASH_A) begin
         st_year = st_year * 14'd10 + {10'd0, dig};
      end else if (at < itsp_pkg::POS_DASH_B) begin
         st_mon = st_mon * 7'd10 + {3'd0, dig};
      end else if (at < itsp_pkg::POS_T) begin
         st_day = st_day * 7'd10 + {3'd0, dig};
      end else if (at < itsp_pkg::POS_COLON_A) begin
         st_hr = st_hr * 7'd10 + {3'd0, dig};
      end else if (at < itsp_pkg::POS_COLON_B) begin
         st_min = st_min * 7'd10 + {3'd0, dig};
      end else begin
         st_sec = st_sec * 7'd10 + {3'd0, dig};
      end

      got = fin;
      res = '0;
      if (!fin) begin
         if (st_pos != itsp_pkg::POS_MAX) st_pos = st_pos + 5'd1;
         return;
      end

      yl = int'(st_year);
      ml = int'(st_mon);
      dl = int'(st_day);
      // day range against the month length also rejects months outside 1..12
      good = !st_bad && at == itsp_pkg::POS_Z && yl <= 9999 && dl >= 1 &&
             dl <= days_in_month(yl, ml) && st_hr <= 7'd23 && st_min <= 7'd59 &&
             st_sec <= 7'd60;
      if (good) begin
         // leap days of years 0..yl-1 counted from 0000-01-01
         days = 365 * yl + (yl + 3) / 4 - (yl + 99) / 100 + (yl + 399) / 400 - DAY0_1970 +
                dl - 1;
         for (int k = 1; k < ml; k++) days += days_in_month(yl, k);
         secs = longint'(days) * 64'sd86400 +
                longint'(int'(st_hr) * 3600 + int'(st_min) * 60 + int'(st_sec));
         res.ok   = 1'b1;
         res.data = {1'b0, secs[38:0]};
      end
      st_pos  = '0;
      st_bad  = 1'b0;
      st_year = '0;
      st_mon  = '0;
      st_day  = '0;
      st_hr   = '0;
      st_min  = '0;
      st_sec  = '0;
   endfunction

   // turn str_buf into stimulus bytes, tlast on the final one
   task automatic queue_string(input bit typed, input bit ok, input longint secs,
                               input bit hold, input bit burst);
      char_item_type it;
      foreach (str_buf[i]) begin
         it       = '0;
         it.ch    = str_buf[i];
         it.fin   = (i == str_buf.size() - 1);
         it.typed = typed;
         it.ok    = ok;
         it.secs  = secs[38:0];
         it.drain = drain_next && i == 0;
         it.hold  = hold && i == 0;
         it.burst = burst;
         char_stream.push_back(it);
      end
      drain_next = 1'b0;
   endtask

   // back-to-back 1..3 byte strings during a long receiver hold-off: fills the queue
   task automatic add_short_burst();
      for (int n = 0; n < SHORT_RUNS; n++) begin
         str_buf.delete();
         repeat ($urandom_range(1, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
         queue_string(1'b0, 1'b0, 64'sd0, n == 0, 1'b1);
      end
   endtask

   // sender: builds the whole stream up front, then plays it out in bursts
   initial begin : sender
      char_item_type it;
      string      txt;
      int         yr, mo, dy, hr, mi, se, pick, gap, burst_left;
      bit         mid_done;
      burst_left = 0;
      mid_done   = 1'b0;

      foreach (stamp_table[i]) begin
         str_buf.delete();
         txt = stamp_table[i].text;
         for (int c = 0; c < txt.len(); c++) str_buf.push_back(txt[c]);
         queue_string(stamp_table[i].typed, stamp_table[i].ok, stamp_table[i].secs,
                      1'b0, 1'b0);
      end

      drain_next = 1'b1;
      add_short_burst();
      while (char_stream.size() < ITEM_TARGET) begin
         if (!mid_done && char_stream.size() >= ITEM_TARGET / 2) begin
            mid_done   = 1'b1;
            drain_next = 1'b1;
            add_short_burst();
            drain_next = 1'b1;
         end
         str_buf.delete();
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            // well-formed stamp, sometimes with one field out of range
            yr = $urandom_range(0, 9);
            yr = yr == 0 ? 0 : yr == 1 ? 9999 : $urandom_range(0, 9999);
            mo = $urandom_range(1, 12);
            dy = $urandom_range(1, days_in_month(yr, mo));
            hr = $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            se = $urandom_range(0, 15) == 0 ? 60 : $urandom_range(0, 59);
            gap = $urandom_range(0, 24);
            if (gap < 2) mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
            else if (gap < 4) dy = $urandom_range(0, 1) ? 0 :
                                   $urandom_range(days_in_month(yr, mo) + 1, 99);
            else if (gap == 4) hr = $urandom_range(24, 99);
            else if (gap == 5) mi = $urandom_range(60, 99);
            else if (gap == 6) se = $urandom_range(61, 99);
            txt = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d%s", yr, mo, dy,
                            $urandom_range(0, 1) ? "T" : "t", hr, mi, se,
                            $urandom_range(0, 1) ? "Z" : "z");
            for (int c = 0; c < txt.len(); c++) str_buf.push_back(txt[c]);
            if (pick >= 60) begin
               // damage: one bad byte, cut short, or run past 20 bytes
               gap = $urandom_range(0, 99);
               if (gap < 40)
                  str_buf[$urandom_range(0, 19)] = 8'($urandom_range(0, 255));
               else if (gap < 70)
                  repeat ($urandom_range(1, 19)) void'(str_buf.pop_back());
               else
                  repeat ($urandom_range(1, 15)) str_buf.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 40)) str_buf.push_back(8'($urandom_range(0, 255)));
         end
         queue_string(1'b0, 1'b0, 64'sd0, 1'b0, 1'b0);
      end

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (char_stream[n]) begin
         it = char_stream[n];
         if (it.drain) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_epochs.size() != 0) @(posedge clock);
         end
         if (it.hold) holds_asked++;
         if (!it.burst && !it.drain) begin
            if (burst_left == 0) begin
               gap        = $urandom_range(1, 8);
               burst_left = $urandom_range(0, 7) == 0 ? 300 : $urandom_range(1, 40);
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end else begin
               burst_left--;
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= it.ch;
         req_tlast  <= it.fin;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_epochs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASS iso8601_utc_timestamp_parser_unit");
      else
         $display("FAIL iso8601_utc_timestamp_parser_unit");
      $finish;
   end

   // receiver: modes of its own, plus a long hold-off on request
   always @(posedge clock) begin : receiver
      int unsigned hold_left;
      int unsigned mode_left;
      int unsigned phase;
      rx_mode_type rx_mode;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         mode_left  = 0;
         phase      = 0;
         rx_mode    = RX_OPEN;
      end else begin
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = LONG_HOLD;
         end
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         phase++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= (phase % 4 == 0);
               default:   rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // predict on every input transfer, score every output transfer
   always @(posedge clock) begin : scoreboard
      char_item_type it;
      epoch_rsp_type want;
      logic          has_res;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            it = char_stream[taken];
            taken++;
            parse_char(req_tdata, req_tlast, has_res, want);
            if (has_res) begin
               if (it.typed) begin
                  want.ok   = it.ok;
                  want.data = {1'b0, it.secs};
               end
               pending_epochs.push_back(want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_epochs.size() == 0) begin
               $display("%0t: unexpected result, parse_ok %0b epoch %h", $time, rsp_tuser,
                        rsp_tdata);
               errors++;
            end else begin
               want = pending_epochs.pop_front();
               if (rsp_tuser !== want.ok) begin
                  $display("%0t: parse_ok expected %0b actual %0b", $time, want.ok, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata !== want.data) begin
                  $display("%0t: epoch expected %h actual %h", $time, want.data, rsp_tdata);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout, %0d results outstanding", $time, pending_epochs.size());
      $display("FAIL iso8601_utc_timestamp_parser_unit");
      $finish;
   end

endmodule

`default_nettype wire
